// File: src/ptuv_pkg.sv
// ----------------------------------------------------------------------------
// ptuv_pkg
// Shared types, constants and helper functions for the texture UV mapper.
// ----------------------------------------------------------------------------
package ptuv_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_TEX_DIM = 4096;
  localparam int FRAC_LIM    = (9999 * (2 ** FRAC_BITS)) / 10000;

  // Angle accumulator width (units of 2^-32 turn) and width of the fraction math.
  localparam int ANG_W  = 34;
  localparam int CALC_W = 36;

  localparam logic signed [ANG_W-1:0]  ANG_HALF  = 34'sh0_8000_0000;
  localparam logic signed [CALC_W-1:0] CALC_HALF = 36'sh0_8000_0000;

  localparam int ATAN_LEN = 24;
  localparam int unsigned ATAN_TAB [ATAN_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef enum logic [2:0] {
    OP_SPHERE   = 3'd0,
    OP_PLANE    = 3'd1,
    OP_CONE     = 3'd2,
    OP_CYLINDER = 3'd3,
    OP_DISC     = 3'd4
  } op_t;

  function automatic logic [12:0] size_eff(input logic [12:0] s);
    if (s == '0) begin
      return 13'd1;
    end else if (s > 13'(MAX_TEX_DIM)) begin
      return 13'(MAX_TEX_DIM);
    end else begin
      return s;
    end
  endfunction

  function automatic logic [FRAC_BITS-1:0] frac_clamp(input logic signed [CALC_W-1:0] f);
    if (f < 0) begin
      return '0;
    end else if (f > CALC_W'(FRAC_LIM)) begin
      return FRAC_BITS'(FRAC_LIM);
    end else begin
      return f[FRAC_BITS-1:0];
    end
  endfunction

  // Quotient to fraction: a negative numerator gives zero, an overflow saturates.
  function automatic logic [FRAC_BITS-1:0] div_frac(input logic [FRAC_BITS-1:0] q,
                                                   input logic neg, input logic ovf);
    if (neg) begin
      return '0;
    end else if (ovf || (q > FRAC_BITS'(FRAC_LIM))) begin
      return FRAC_BITS'(FRAC_LIM);
    end else begin
      return q;
    end
  endfunction

endpackage

// File: src/ptuv_delay.sv
// ----------------------------------------------------------------------------
// ptuv_delay
// Fixed-length register delay line that holds while the pipeline is stalled.
// ----------------------------------------------------------------------------
module ptuv_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign dout = sr[N-1];

endmodule

// File: src/ptuv_div.sv
// ----------------------------------------------------------------------------
// ptuv_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptuv_div #(
  parameter int NW = 48,
  parameter int DW = 31,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [TW-1:0] tag_out
);

  localparam int CW = (NW > DW + QW - 1) ? NW : DW + QW - 1;

  logic [CW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [TW-1:0] tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [CW-1:0] rem_in;
    logic [CW-1:0] trial;
    logic [CW:0]   diff;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [TW-1:0] tag_in_k;

    if (k == 0) begin : g_first
      assign rem_in   = CW'(num);
      assign quo_in   = '0;
      assign den_in   = den;
      assign tag_in_k = tag_in;
    end else begin : g_next
      assign rem_in   = rem_r[k-1];
      assign quo_in   = quo_r[k-1];
      assign den_in   = den_r[k-1];
      assign tag_in_k = tag_r[k-1];
    end

    assign trial = CW'(den_in) << (QW - 1 - k);
    assign diff  = {1'b0, rem_in} - {1'b0, trial};

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[CW]) begin
          rem_r[k] <= diff[CW-1:0];
          quo_r[k] <= quo_in | (QW'(1) << (QW - 1 - k));
        end else begin
          rem_r[k] <= rem_in;
          quo_r[k] <= quo_in;
        end
        den_r[k] <= den_in;
        tag_r[k] <= tag_in_k;
      end
    end
  end

  assign quo     = quo_r[QW-1];
  assign rem     = rem_r[QW-1][DW-1:0];
  assign tag_out = tag_r[QW-1];

endmodule

// File: src/ptuv_isqrt.sv
// ----------------------------------------------------------------------------
// ptuv_isqrt
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ptuv_isqrt #(
  parameter int TW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   n_in,
  input  logic [TW-1:0] tag_in,
  output logic [31:0]   root,
  output logic [TW-1:0] tag_out
);

  localparam int STEPS = 32;

  logic [63:0]   n_r   [STEPS];
  logic [63:0]   res_r [STEPS];
  logic [TW-1:0] tag_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [63:0]   n_i;
    logic [63:0]   res_i;
    logic [TW-1:0] tag_i;
    logic [63:0]   bitv;
    logic [63:0]   trial;

    if (k == 0) begin : g_first
      assign n_i   = n_in;
      assign res_i = '0;
      assign tag_i = tag_in;
    end else begin : g_next
      assign n_i   = n_r[k-1];
      assign res_i = res_r[k-1];
      assign tag_i = tag_r[k-1];
    end

    assign bitv  = 64'(1) << (62 - 2 * k);
    assign trial = res_i + bitv;

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_i >= trial) begin
          n_r[k]   <= n_i - trial;
          res_r[k] <= (res_i >> 1) + bitv;
        end else begin
          n_r[k]   <= n_i;
          res_r[k] <= res_i >> 1;
        end
        tag_r[k] <= tag_i;
      end
    end
  end

  assign root    = res_r[STEPS-1][31:0];
  assign tag_out = tag_r[STEPS-1];

endmodule

// File: src/ptuv_cordic.sv
// ----------------------------------------------------------------------------
// ptuv_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in units of 2^-32 turn.
// ----------------------------------------------------------------------------
module ptuv_cordic import ptuv_pkg::*; #(
  parameter int W      = 36,
  parameter int STAGES = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [W-1:0]     x_in,
  input  logic signed [W-1:0]     y_in,
  output logic signed [ANG_W-1:0] angle
);

  logic signed [W-1:0]     xr [STAGES+1];
  logic signed [W-1:0]     yr [STAGES+1];
  logic signed [ANG_W-1:0] zr [STAGES+1];
  logic [STAGES:0]         zero_r;

  // Left half plane is folded into the right half by a half turn.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[W-1]) begin
        xr[0] <= -x_in;
        yr[0] <= -y_in;
        zr[0] <= y_in[W-1] ? -ANG_HALF : ANG_HALF;
      end else begin
        xr[0] <= x_in;
        yr[0] <= y_in;
        zr[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [W-1:0]     dx;
    logic signed [W-1:0]     dy;
    logic signed [ANG_W-1:0] step;

    assign dx   = xr[i] >>> i;
    assign dy   = yr[i] >>> i;
    assign step = ANG_W'(ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yr[i][W-1]) begin
          xr[i+1] <= xr[i] + dy;
          yr[i+1] <= yr[i] - dx;
          zr[i+1] <= zr[i] + step;
        end else begin
          xr[i+1] <= xr[i] - dy;
          yr[i+1] <= yr[i] + dx;
          zr[i+1] <= zr[i] - step;
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  assign angle = zero_r[STAGES] ? '0 : zr[STAGES];

endmodule

// File: src/primitive_texture_uv_mapper_core.sv
// ----------------------------------------------------------------------------
// primitive_texture_uv_mapper_core
// Maps object-space hit points to texel indices for five primitive kinds.
// ----------------------------------------------------------------------------
// Usage: a hit point and its primitive kind enter on the input channel
// (in_valid / in_stall); one texel index pair leaves on the output channel
// (out_valid / out_stall). A transaction completes when valid is high and
// stall is low.
// The path is set by the 32-step square root for the sphere followed by the
// second CORDIC, plus the decode, operand, fraction-selection and scaling
// registers and the output register. One transaction per cycle is sustained
// while the receiver does not stall.
// When the receiver stalls, the output register holds its result and a skid
// register takes the next one; the whole pipeline then holds, and in_stall
// is raised until the skid register drains. No result is lost or repeated.
// Reset clears all valid bits and the output channel; payload registers
// are not reset. There is no configuration and no stored state.
// ----------------------------------------------------------------------------
module primitive_texture_uv_mapper_core import ptuv_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  input  logic [12:0]        tex_width,
  input  logic [12:0]        tex_height,
  input  logic [30:0]        extent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        u_index,
  output logic [11:0]        v_index
);

  localparam int DF = CORDIC_STAGES + 35;
  localparam int L  = DF + 2;
  localparam int NUM_W = 48;

  logic         adv;
  logic         skid_vld;
  logic [L-1:0] vld;

  assign adv      = !skid_vld;
  assign in_stall = skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  // Stage 1: decode, products and division numerators.
  logic [12:0]        w0;
  logic [12:0]        h0;
  logic [30:0]        e0;
  logic signed [48:0] e49;
  logic signed [48:0] na0;
  logic signed [48:0] nb0;
  logic signed [63:0] sqx0;
  logic signed [63:0] sqz0;
  logic signed [45:0] pu0;
  logic signed [45:0] pv0;

  assign w0   = size_eff(tex_width);
  assign h0   = size_eff(tex_height);
  assign e0   = (extent == '0) ? 31'd1 : extent;
  assign e49  = signed'(49'(e0));
  assign sqx0 = px * px;
  assign sqz0 = pz * pz;
  assign pu0  = px * signed'({1'b0, w0});
  assign pv0  = py * signed'({1'b0, h0});
  assign nb0  = (49'(py) + e49) <<< (FRAC_BITS - 1);

  always_comb begin
    if (opcode == OP_DISC) begin
      na0 = (49'(px) + e49) <<< (FRAC_BITS - 1);
    end else begin
      na0 = (e49 <<< (FRAC_BITS - 1)) - (49'(pz) <<< FRAC_BITS);
    end
  end

  logic [2:0]         s1_op;
  logic [12:0]        s1_w;
  logic [12:0]        s1_h;
  logic [30:0]        s1_e;
  logic signed [31:0] s1_cx;
  logic signed [31:0] s1_cy;
  logic signed [31:0] s1_py;
  logic [63:0]        s1_sqx;
  logic [63:0]        s1_sqz;
  logic signed [45:0] s1_pu;
  logic signed [45:0] s1_pv;
  logic signed [48:0] s1_na;
  logic signed [48:0] s1_nb;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op  <= opcode;
      s1_w   <= w0;
      s1_h   <= h0;
      s1_e   <= e0;
      s1_cx  <= px;
      s1_cy  <= (opcode == OP_SPHERE) ? pz : py;
      s1_py  <= py;
      s1_sqx <= sqx0;
      s1_sqz <= sqz0;
      s1_pu  <= pu0;
      s1_pv  <= pv0;
      s1_na  <= na0;
      s1_nb  <= nb0;
    end
  end

  // Stage 2: radius squared, divider operands and overflow checks.
  logic signed [23:0] qu1;
  logic signed [23:0] qv1;

  assign qu1 = 24'(s1_pu >>> (FRAC_BITS + 4));
  assign qv1 = 24'(s1_pv >>> (FRAC_BITS + 4));

  logic [12:0]        s2_w;
  logic [12:0]        s2_h;
  logic [30:0]        s2_e;
  logic [63:0]        s2_nsq;
  logic [31:0]        s2_py;
  logic [NUM_W-1:0]   s2_numa;
  logic [NUM_W-1:0]   s2_numb;
  logic [1:0]         s2_flga;
  logic [1:0]         s2_flgb;
  logic [23:0]        s2_au;
  logic [23:0]        s2_av;
  logic               s2_negu;
  logic               s2_negv;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_w    <= s1_w;
      s2_h    <= s1_h;
      s2_e    <= s1_e;
      s2_nsq  <= s1_sqx + s1_sqz;
      s2_py   <= s1_py;
      s2_numa <= s1_na[NUM_W-1:0];
      s2_numb <= s1_nb[NUM_W-1:0];
      s2_flga <= {s1_na[48], s1_na[NUM_W-1:FRAC_BITS] >= {1'b0, s1_e}};
      s2_flgb <= {s1_nb[48], s1_nb[NUM_W-1:FRAC_BITS] >= {1'b0, s1_e}};
      s2_au   <= qu1[23] ? ~qu1 : qu1;
      s2_av   <= qv1[23] ? ~qv1 : qv1;
      s2_negu <= qu1[23];
      s2_negv <= qv1[23];
    end
  end

  // Angle around the axis (sphere u, cone and cylinder u).
  logic signed [ANG_W-1:0] ang1;
  logic signed [ANG_W-1:0] ang1_d;

  ptuv_cordic #(.W(CALC_W), .STAGES(CORDIC_STAGES)) u_cordic_u (
    .clk   (clk),
    .en    (adv),
    .x_in  (CALC_W'(s1_cx)),
    .y_in  (CALC_W'(s1_cy)),
    .angle (ang1)
  );

  ptuv_delay #(.W(ANG_W), .N(DF - CORDIC_STAGES - 2)) u_dly_ang (
    .clk  (clk),
    .en   (adv),
    .din  (ang1),
    .dout (ang1_d)
  );

  // Sphere latitude: root of x*x + z*z, then a second angle against y.
  logic [31:0]             root;
  logic signed [31:0]      sq_py;
  logic signed [ANG_W-1:0] ang2;

  ptuv_isqrt #(.TW(32)) u_isqrt (
    .clk     (clk),
    .en      (adv),
    .n_in    (s2_nsq),
    .tag_in  (s2_py),
    .root    (root),
    .tag_out (sq_py)
  );

  ptuv_cordic #(.W(CALC_W), .STAGES(CORDIC_STAGES)) u_cordic_v (
    .clk   (clk),
    .en    (adv),
    .x_in  (signed'(CALC_W'(root))),
    .y_in  (CALC_W'(sq_py)),
    .angle (ang2)
  );

  // Height and disc ratios.
  logic [FRAC_BITS-1:0] qa;
  logic [FRAC_BITS-1:0] qb;
  logic [30:0]          ra_unused_n;
  logic [30:0]          rb_unused_n;
  logic [1:0]           fa;
  logic [1:0]           fb;
  logic [2*FRAC_BITS+3:0] ab_d;

  ptuv_div #(.NW(NUM_W), .DW(31), .QW(FRAC_BITS), .TW(2)) u_div_a (
    .clk     (clk),
    .en      (adv),
    .num     (s2_numa),
    .den     (s2_e),
    .tag_in  (s2_flga),
    .quo     (qa),
    .rem     (ra_unused_n),
    .tag_out (fa)
  );

  ptuv_div #(.NW(NUM_W), .DW(31), .QW(FRAC_BITS), .TW(2)) u_div_b (
    .clk     (clk),
    .en      (adv),
    .num     (s2_numb),
    .den     (s2_e),
    .tag_in  (s2_flgb),
    .quo     (qb),
    .rem     (rb_unused_n),
    .tag_out (fb)
  );

  ptuv_delay #(.W(2 * FRAC_BITS + 4), .N(DF - FRAC_BITS - 2)) u_dly_ab (
    .clk  (clk),
    .en   (adv),
    .din  ({qa, fa, qb, fb}),
    .dout (ab_d)
  );

  // Plane wrap: remainders of the tile coordinates.
  logic [23:0] qc_unused_n;
  logic [23:0] qd_unused_n;
  logic [12:0] rc;
  logic [12:0] rd;
  logic        nc;
  logic        nd;
  logic [27:0] cd_d;

  ptuv_div #(.NW(24), .DW(13), .QW(24), .TW(1)) u_div_c (
    .clk     (clk),
    .en      (adv),
    .num     (s2_au),
    .den     (s2_w),
    .tag_in  (s2_negu),
    .quo     (qc_unused_n),
    .rem     (rc),
    .tag_out (nc)
  );

  ptuv_div #(.NW(24), .DW(13), .QW(24), .TW(1)) u_div_d (
    .clk     (clk),
    .en      (adv),
    .num     (s2_av),
    .den     (s2_h),
    .tag_in  (s2_negv),
    .quo     (qd_unused_n),
    .rem     (rd),
    .tag_out (nd)
  );

  ptuv_delay #(.W(28), .N(DF - 26)) u_dly_cd (
    .clk  (clk),
    .en   (adv),
    .din  ({rc, nc, rd, nd}),
    .dout (cd_d)
  );

  logic [28:0] ctl_d;

  ptuv_delay #(.W(29), .N(DF - 1)) u_dly_ctl (
    .clk  (clk),
    .en   (adv),
    .din  ({s1_op, s1_w, s1_h}),
    .dout (ctl_d)
  );

  // Fraction selection.
  logic [2:0]           f_op;
  logic [12:0]          f_w;
  logic [12:0]          f_h;
  logic [FRAC_BITS-1:0] d_qa;
  logic [FRAC_BITS-1:0] d_qb;
  logic [1:0]           d_fa;
  logic [1:0]           d_fb;
  logic [12:0]          d_rc;
  logic [12:0]          d_rd;
  logic                 d_nc;
  logic                 d_nd;
  logic [FRAC_BITS-1:0] frac_a;
  logic [FRAC_BITS-1:0] frac_b;
  logic [FRAC_BITS-1:0] sph_u;
  logic [FRAC_BITS-1:0] sph_v;
  logic [FRAC_BITS-1:0] cyl_u;
  logic [12:0]          mu;
  logic [12:0]          mv;
  logic [FRAC_BITS-1:0] fu_next;
  logic [FRAC_BITS-1:0] fv_next;

  assign {f_op, f_w, f_h}             = ctl_d;
  assign {d_qa, d_fa, d_qb, d_fb}     = ab_d;
  assign {d_rc, d_nc, d_rd, d_nd}     = cd_d;
  assign frac_a = div_frac(d_qa, d_fa[1], d_fa[0]);
  assign frac_b = div_frac(d_qb, d_fb[1], d_fb[0]);
  assign sph_u  = frac_clamp((CALC_HALF - CALC_W'(ang1_d)) >>> (32 - FRAC_BITS));
  assign sph_v  = frac_clamp((CALC_HALF - (CALC_W'(ang2) <<< 1)) >>> (32 - FRAC_BITS));
  assign cyl_u  = frac_clamp((CALC_HALF + CALC_W'(ang1_d)) >>> (32 - FRAC_BITS));
  // A negative tile coordinate was complemented, so its floor remainder is mirrored.
  assign mu     = d_nc ? (f_w - 13'd1 - d_rc) : d_rc;
  assign mv     = d_nd ? (f_h - 13'd1 - d_rd) : d_rd;

  always_comb begin
    unique case (f_op)
      OP_SPHERE: begin
        fu_next = sph_u;
        fv_next = sph_v;
      end
      OP_CONE, OP_CYLINDER: begin
        fu_next = cyl_u;
        fv_next = frac_a;
      end
      OP_DISC: begin
        fu_next = frac_a;
        fv_next = frac_b;
      end
      default: begin
        fu_next = '0;
        fv_next = '0;
      end
    endcase
  end

  logic [2:0]           f1_op;
  logic [12:0]          f1_w;
  logic [12:0]          f1_h;
  logic [FRAC_BITS-1:0] f1_fu;
  logic [FRAC_BITS-1:0] f1_fv;
  logic [11:0]          f1_pu;
  logic [11:0]          f1_pv;

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_op <= f_op;
      f1_w  <= f_w;
      f1_h  <= f_h;
      f1_fu <= fu_next;
      f1_fv <= fv_next;
      f1_pu <= mu[11:0];
      f1_pv <= 12'(f_h - 13'd1 - mv);
    end
  end

  // Scale fractions to texel indices.
  logic [FRAC_BITS+12:0] prod_u;
  logic [FRAC_BITS+12:0] prod_v;
  logic [11:0]           iu;
  logic [11:0]           iv;
  logic [11:0]           u_next;
  logic [11:0]           v_next;

  assign prod_u = f1_fu * f1_w;
  assign prod_v = f1_fv * f1_h;
  assign iu     = prod_u[FRAC_BITS +: 12];
  assign iv     = prod_v[FRAC_BITS +: 12];

  always_comb begin
    unique case (f1_op)
      OP_SPHERE, OP_CONE, OP_CYLINDER: begin
        u_next = iu;
        v_next = iv;
      end
      OP_DISC: begin
        u_next = iu;
        v_next = 12'(f1_h - 13'd1 - {1'b0, iv});
      end
      OP_PLANE: begin
        u_next = f1_pu;
        v_next = f1_pv;
      end
      default: begin
        u_next = '0;
        v_next = '0;
      end
    endcase
  end

  logic [11:0] f2_u;
  logic [11:0] f2_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_u <= u_next;
      f2_v <= v_next;
    end
  end

  // Output register with a skid register behind it.
  logic [11:0] skid_u;
  logic [11:0] skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_vld) begin
          out_valid <= 1'b1;
          skid_vld  <= 1'b0;
        end else begin
          out_valid <= vld[L-1];
        end
      end else if (adv && vld[L-1]) begin
        skid_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_vld) begin
        u_index <= skid_u;
        v_index <= skid_v;
      end else begin
        u_index <= f2_u;
        v_index <= f2_v;
      end
    end else if (!skid_vld) begin
      skid_u <= f2_u;
      skid_v <= f2_v;
    end
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the texture UV mapper: a bit-exact predictor of
// every primitive kind, directed corners, then random hit points under
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import ptuv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 20000;
  localparam int LATENCY     = 16 + 37;

  typedef struct {
    logic [11:0] u;
    logic [11:0] v;
  } texel_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         opcode;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  logic [12:0]        tex_width;
  logic [12:0]        tex_height;
  logic [30:0]        extent;
  logic               out_valid;
  logic               out_stall;
  logic [11:0]        u_index;
  logic [11:0]        v_index;

  texel_t texel_queue[$];
  int     mismatches;
  int     idle_cycles;
  bit     hold_output;
  int     hold_cycles;
  int     recv_wait;

  primitive_texture_uv_mapper_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Angle of (y, x) in units of 2^-32 turn.
  function automatic longint angle_turns(longint x, longint y);
    longint acc;
    longint dx;
    longint dy;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      acc = (y >= 0) ? 64'sh8000_0000 : -64'sh8000_0000;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; acc += ATAN_TAB[i];
      end else begin
        x -= dy; y += dx; acc -= ATAN_TAB[i];
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_size(logic [12:0] s);
    if (s == 0) return 1;
    if (s > MAX_TEX_DIM) return MAX_TEX_DIM;
    return s;
  endfunction

  function automatic longint scale_index(longint f, longint size);
    if (f < 0) f = 0;
    if (f > FRAC_LIM) f = FRAC_LIM;
    return (f * size) >>> FRAC_BITS;
  endfunction

  function automatic longint ratio(longint num, longint e);
    if (num < 0) return 0;
    return num / e;
  endfunction

  function automatic longint tile_wrap(longint c, longint size);
    longint q;
    longint m;
    q = (c * size) >>> (FRAC_BITS + 4);
    m = q % size;
    if (m < 0) m += size;
    return m;
  endfunction

  function automatic texel_t map_texel(logic [2:0] op, longint x, longint y, longint z,
                                       logic [12:0] w13, logic [12:0] h13, logic [30:0] e31);
    texel_t t;
    longint w;
    longint h;
    longint e;
    longint tu;
    longint tv;
    longint r;
    longint uu;
    longint vv;
    w = clamp_size(w13);
    h = clamp_size(h13);
    e = (e31 == 0) ? 1 : longint'(e31);
    uu = 0;
    vv = 0;
    case (op)
      OP_SPHERE: begin
        tu = angle_turns(x, z);
        r = longint'(root_floor(x * x + z * z));
        tv = angle_turns(r, y);
        uu = scale_index((64'sh8000_0000 - tu) >>> 16, w);
        vv = scale_index((64'sh8000_0000 - 2 * tv) >>> 16, h);
      end
      OP_PLANE: begin
        uu = tile_wrap(x, w);
        vv = h - 1 - tile_wrap(y, h);
      end
      OP_CONE, OP_CYLINDER: begin
        tu = angle_turns(x, y);
        uu = scale_index((64'sh8000_0000 + tu) >>> 16, w);
        vv = scale_index(ratio(e * 32768 - z * 65536, e), h);
      end
      OP_DISC: begin
        uu = scale_index(ratio((x + e) * 32768, e), w);
        vv = h - 1 - scale_index(ratio((y + e) * 32768, e), h);
      end
      default: ;
    endcase
    t.u = uu[11:0];
    t.v = vv[11:0];
    return t;
  endfunction

  // The task returns at the falling edge after its transaction with valid still high,
  // so the next call either drops valid for its gap or drives the next item at once.
  task automatic send_hit(logic [2:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                          logic [12:0] w, logic [12:0] h, logic [30:0] e);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    px         <= x;
    py         <= y;
    pz         <= z;
    tex_width  <= w;
    tex_height <= h;
    extent     <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    texel_queue.push_back(map_texel(op, signed'(x), signed'(y), signed'(z), w, h, e));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
      2: return 32'($signed($urandom_range(0, 2 ** 16)) - 2 ** 15);
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  function automatic logic [12:0] rand_size();
    case ($urandom_range(0, 4))
      0: return 13'($urandom());
      1: return 13'($urandom_range(0, 16));
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [30:0] rand_extent();
    case ($urandom_range(0, 2))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 16));
      default: return 31'($urandom_range(1, 2 ** 22));
    endcase
  endfunction

  task automatic test_corners();
    send_hit(OP_SPHERE, 0, 0, 0, 64, 64, 1);
    send_hit(OP_SPHERE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 4096, 4096, 1);
    send_hit(OP_SPHERE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8191, 0, 5);
    send_hit(OP_SPHERE, -65536, 0, 0, 256, 256, 1);
    send_hit(OP_SPHERE, -65536, 0, -1, 256, 256, 1);
    send_hit(OP_PLANE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 4096, 4096, 0);
    send_hit(OP_PLANE, -1, -1, 0, 0, 8191, 1);
    send_hit(OP_PLANE, 32'h0010_0000, 32'hFFF0_0000, 0, 16, 17, 1);
    send_hit(OP_CONE, 0, 0, 32'h8000_0000, 128, 128, 0);
    send_hit(OP_CONE, -1, 0, 32'h7FFF_FFFF, 128, 128, 31'h7FFF_FFFF);
    send_hit(OP_CYLINDER, 65536, -65536, 0, 4096, 4096, 65536);
    send_hit(OP_CYLINDER, -65536, -65536, -65536, 4097, 4096, 31'h7FFF_FFFF);
    send_hit(OP_DISC, 32'h8000_0000, 32'h7FFF_FFFF, 0, 512, 512, 0);
    send_hit(OP_DISC, 65536, -65536, 0, 4096, 4096, 65536);
    send_hit(OP_DISC, 0, 0, 0, 8191, 8191, 31'h7FFF_FFFF);
    for (int op = 5; op < 8; op++) send_hit(3'(op), -1, -1, -1, 8191, 8191, 31'h7FFF_FFFF);
    send_hit(OP_SPHERE, 0, 0, 0, 1, 1, 0);
  endtask

  task automatic test_random(int count);
    logic [2:0] op;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 40) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_hit(op, rand_coord(), rand_coord(), rand_coord(), rand_size(), rand_size(),
               rand_extent());
    end
  endtask

  // Back pressure: the receiver holds off long enough for the pipeline to fill.
  task automatic test_backpressure();
    hold_output = 1'b1;
    hold_cycles = 600;
    test_random(120);
  endtask

  // Each result waits a freshly drawn number of cycles before it is taken.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      if (hold_output) hold_output <= 1'b0;
      if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait <= recv_wait - 1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid) recv_wait <= $urandom_range(0, 7);
      end
    end
  end

  always @(posedge clk) begin
    texel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (texel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction u=%0d v=%0d", u_index, v_index);
      end else begin
        want = texel_queue.pop_front();
        if (want.u !== u_index || want.v !== v_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected u=%0d v=%0d, got u=%0d v=%0d",
                     want.u, want.v, u_index, v_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    opcode = '0;
    px = '0;
    py = '0;
    pz = '0;
    tex_width = '0;
    tex_height = '0;
    extent = '0;
    mismatches = 0;
    idle_cycles = 0;
    hold_output = 1'b0;
    hold_cycles = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_corners();
    test_backpressure();
    test_random(1700);
    in_valid <= 1'b0;
    while (texel_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: primitive_texture_uv_mapper_core.f
src/ptuv_pkg.sv
src/ptuv_delay.sv
src/ptuv_div.sv
src/ptuv_isqrt.sv
src/ptuv_cordic.sv
src/primitive_texture_uv_mapper_core.sv
tb/sv/tb.sv
